// ===== rtl/igmphm_pkg.sv =====
package igmphm_pkg;

  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  typedef enum logic [2:0] {
    REQ_QUERY = 3'd0,
    REQ_V1REP = 3'd1,
    REQ_V2REP = 3'd2,
    REQ_JOIN  = 3'd3,
    REQ_LEAVE = 3'd4,
    REQ_FAST  = 3'd5,
    REQ_SLOW  = 3'd6
  } req_e;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_QUERY  = 3'd1;
  localparam logic [2:0] ST_BAD_REPORT = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

  localparam logic [1:0] KIND_V1_REPORT = 2'd0;
  localparam logic [1:0] KIND_V2_REPORT = 2'd1;
  localparam logic [1:0] KIND_LEAVE     = 2'd2;

  localparam logic [2:0] CFG_LOOPBACK    = 3'd0;
  localparam logic [2:0] CFG_SEED        = 3'd1;
  localparam logic [2:0] CFG_FAST_HZ     = 3'd2;
  localparam logic [2:0] CFG_UNSOLICITED = 3'd3;
  localparam logic [2:0] CFG_AGE_LIMIT   = 3'd4;
  localparam logic [2:0] CFG_ALL_HOSTS   = 3'd5;
  localparam logic [2:0] CFG_ALL_ROUTERS = 3'd6;

  typedef struct packed {
    logic [2:0]  iface;
    logic [31:0] group;
    logic [7:0]  timer;
    logic        rep_last;
  } entry_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DISP = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_EVAL = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_WEND = 8'b0010_0000,
    S_EMIT = 8'b0100_0000,
    S_STAT = 8'b1000_0000
  } state_e;

  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    lfsr_step = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
  endfunction

  function automatic logic is_mcast(input logic [31:0] a);
    is_mcast = (a[31:28] == 4'hE);
  endfunction

endpackage

// ===== rtl/igmphm_mod.sv =====
module igmphm_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [7:0]  den_i,
  output logic        done_o,
  output logic [7:0]  rem_o
);
  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] num_q;
  logic [7:0]  den_q;
  logic [7:0]  rem_q;
  logic [8:0]  sh;

  assign sh = {rem_q, num_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring remainder, one dividend bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[30:0], 1'b0};
      if (sh >= {1'b0, den_q}) rem_q <= 8'(sh - {1'b0, den_q});
      else rem_q <= sh[7:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

// ===== rtl/igmpv2_host_membership_engine.sv =====
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o   | req_type, iface, group_addr, dst_addr,
//         |           |                           | max_resp_code, from_self
// out     | output    | out_valid_o / out_ready_i | send_*, status, last
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// one request at a time; a table walk reads its entries one by one through the
// table memory and waits on the bit-serial modulo unit for each random delay
// drawn; joins, leaves and reports stop at the matching entry
// reset clears the valid bits and querier state, presets the config, sets the lfsr to 1
// a stalled output holds the sequencer; the next request is taken while the final
// status still waits in the output register
module igmpv2_host_membership_engine #(
  parameter int TABLE_DEPTH = 16,
  parameter int IFACE_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [2:0]  iface_i,
  input  logic [31:0] group_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [7:0]  max_resp_code_i,
  input  logic        from_self_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_valid_o,
  output logic [1:0]  send_kind_o,
  output logic [31:0] send_group_o,
  output logic [31:0] send_dst_o,
  output logic [2:0]  send_iface_o,
  output logic [2:0]  status_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import igmphm_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // configuration
  logic [7:0]  loop_mask_q;
  logic [3:0]  fast_hz_q;
  logic [7:0]  unsol_q;
  logic [15:0] age_lim_q;
  logic [31:0] all_hosts_q;
  logic [31:0] all_routers_q;

  // table memory
  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic        mem_we;
  logic [IW-1:0] mem_wa;
  entry_t      mem_wd;

  // querier state
  logic [IFACE_COUNT-1:0] v1_q, v1_d;
  logic [15:0] age_q [IFACE_COUNT];
  logic [15:0] age_d [IFACE_COUNT];

  state_e state_q, state_d;
  logic [31:0] lfsr_q, lfsr_d;
  logic [2:0]  req_q, ifc_q, code_unused;
  logic [31:0] grp_q, dst_q;
  logic [7:0]  code_q;
  logic        self_q;
  logic [11:0] prod_q;
  logic [7:0]  t_q, t_d;
  logic [2:0]  st_q, st_d;
  logic [CW-1:0] idx_q, idx_d;
  logic        found_q, found_d, free_q, free_d, hit_rl_q, hit_rl_d;
  logic [IW-1:0] hit_q, hit_d, free_idx_q, free_idx_d;
  entry_t      ent_q, ent_d;
  logic [1:0]  pk_q, pk_d;
  logic [31:0] pg_q, pg_d, pd_q, pd_d;
  logic [2:0]  pi_q, pi_d;

  // output register
  logic        out_valid_q;
  logic        ov_sv_q;
  logic [1:0]  ov_kind_q;
  logic [31:0] ov_grp_q, ov_dst_q;
  logic [2:0]  ov_ifc_q, ov_st_q;
  logic        ov_last_q;
  logic        out_free, push, push_last;

  logic        div_start, div_done;
  logic [31:0] div_num;
  logic [7:0]  div_den, div_rem;

  logic        in_acc;
  logic [24:0] tq_full;
  logic [12:0] tq;
  logic        ifc_loop, ifc_v1, ent_v1, ent_match, ent_valid;
  logic [7:0]  tdec;

  assign code_unused = 3'd0;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  igmphm_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // code * fast_hz / 10 by reciprocal
  assign tq_full = 25'(prod_q) * 25'd6554;
  assign tq      = tq_full[24:16] == 9'd0 ? 13'd0 : 13'(tq_full[24:16]);

  always_comb begin
    ifc_v1 = 1'b0;
    ent_v1 = 1'b0;
    for (int i = 0; i < IFACE_COUNT; i++) begin
      if (5'(i) == {2'b0, ifc_q} && v1_q[i]) ifc_v1 = 1'b1;
      if (5'(i) == {2'b0, rdata_q.iface} && v1_q[i]) ent_v1 = 1'b1;
    end
  end

  assign ifc_loop  = loop_mask_q[ifc_q];
  assign ent_valid = valid_q[idx_q[IW-1:0]];
  assign ent_match = ent_valid && rdata_q.iface == ifc_q && rdata_q.group == grp_q;
  assign tdec      = rdata_q.timer - 8'd1;

  always_comb begin
    state_d    = state_q;
    lfsr_d     = lfsr_q;
    t_d        = t_q;
    st_d       = st_q;
    idx_d      = idx_q;
    found_d    = found_q;
    free_d     = free_q;
    hit_rl_d   = hit_rl_q;
    hit_d      = hit_q;
    free_idx_d = free_idx_q;
    ent_d      = ent_q;
    pk_d       = pk_q;
    pg_d       = pg_q;
    pd_d       = pd_q;
    pi_d       = pi_q;
    valid_d    = valid_q;
    v1_d       = v1_q;
    age_d      = age_q;
    mem_we     = 1'b0;
    mem_wa     = idx_q[IW-1:0];
    mem_wd     = rdata_q;
    push       = 1'b0;
    push_last  = 1'b0;
    div_start  = 1'b0;
    div_num    = lfsr_step(lfsr_q);
    div_den    = 8'd1;

    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DISP;
      end
      S_DISP: begin
        st_d    = ST_OK;
        idx_d   = '0;
        found_d = 1'b0;
        free_d  = 1'b0;
        state_d = S_STAT;
        if (req_q <= REQ_LEAVE && {2'b0, ifc_q} >= 5'(IFACE_COUNT)) begin
          state_d = S_STAT;
        end else begin
          case (req_q)
            REQ_QUERY: begin
              if (!ifc_loop) begin
                if (code_q == 8'd0) begin
                  for (int i = 0; i < IFACE_COUNT; i++) begin
                    if (5'(i) == {2'b0, ifc_q}) begin
                      v1_d[i]  = 1'b1;
                      age_d[i] = '0;
                    end
                  end
                  t_d = unsol_q;
                  if (dst_q != all_hosts_q || grp_q != 32'd0) st_d = ST_BAD_QUERY;
                  else state_d = S_RD;
                end else begin
                  if (tq == 13'd0) t_d = 8'd1;
                  else if (tq > 13'd255) t_d = 8'd255;
                  else t_d = tq[7:0];
                  if (grp_q != 32'd0 && !is_mcast(grp_q)) st_d = ST_BAD_QUERY;
                  else state_d = S_RD;
                end
              end
            end
            REQ_V1REP, REQ_V2REP: begin
              if (!self_q && !ifc_loop) begin
                if (!is_mcast(grp_q)) st_d = ST_BAD_REPORT;
                else state_d = S_RD;
              end
            end
            REQ_JOIN, REQ_LEAVE, REQ_FAST: state_d = S_RD;
            REQ_SLOW: begin
              for (int i = 0; i < IFACE_COUNT; i++) begin
                if (v1_q[i]) begin
                  age_d[i] = (age_q[i] == 16'hFFFF) ? age_q[i] : age_q[i] + 16'd1;
                  if (age_d[i] >= age_lim_q) v1_d[i] = 1'b0;
                end
              end
            end
            default: state_d = S_STAT;
          endcase
        end
      end
      S_RD: begin
        if (idx_q == CW'(TABLE_DEPTH)) state_d = S_WEND;
        else state_d = S_EVAL;
      end
      S_EVAL: begin
        idx_d   = idx_q + CW'(1);
        state_d = S_RD;
        case (req_q)
          REQ_QUERY: begin
            if (ent_valid && rdata_q.iface == ifc_q && rdata_q.group != all_hosts_q &&
                (grp_q == 32'd0 || grp_q == rdata_q.group) &&
                (rdata_q.timer == 8'd0 || rdata_q.timer > t_q)) begin
              ent_d     = rdata_q;
              idx_d     = idx_q;
              lfsr_d    = lfsr_step(lfsr_q);
              div_start = 1'b1;
              div_den   = (t_q == 8'd0) ? 8'd1 : t_q;
              state_d   = S_DIV;
            end
          end
          REQ_V1REP, REQ_V2REP: begin
            if (ent_match) begin
              mem_we          = 1'b1;
              mem_wd.timer    = 8'd0;
              mem_wd.rep_last = 1'b0;
              state_d         = S_STAT;
            end
          end
          REQ_JOIN, REQ_LEAVE: begin
            if (ent_match) begin
              found_d  = 1'b1;
              hit_d    = idx_q[IW-1:0];
              hit_rl_d = rdata_q.rep_last;
              state_d  = S_WEND;
            end else if (!ent_valid && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = idx_q[IW-1:0];
            end
          end
          REQ_FAST: begin
            if (ent_valid && rdata_q.timer != 8'd0) begin
              mem_we       = 1'b1;
              mem_wd.timer = tdec;
              if (tdec == 8'd0) begin
                mem_wd.rep_last = 1'b1;
                pk_d    = ent_v1 ? KIND_V1_REPORT : KIND_V2_REPORT;
                pg_d    = rdata_q.group;
                pd_d    = rdata_q.group;
                pi_d    = rdata_q.iface;
                idx_d   = idx_q;
                state_d = S_EMIT;
              end
            end
          end
          default: state_d = S_STAT;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          mem_we = 1'b1;
          if (req_q == REQ_JOIN) begin
            mem_wa          = free_idx_q;
            mem_wd.iface    = ifc_q;
            mem_wd.group    = grp_q;
            mem_wd.timer    = div_rem + 8'd1;
            mem_wd.rep_last = 1'b1;
            state_d         = S_STAT;
          end else begin
            mem_wd       = ent_q;
            mem_wd.timer = div_rem + 8'd1;
            idx_d        = idx_q + CW'(1);
            state_d      = S_RD;
          end
        end
      end
      S_WEND: begin
        state_d = S_STAT;
        if (req_q == REQ_JOIN && !found_q) begin
          if (!free_q) begin
            st_d = ST_FULL;
          end else begin
            valid_d[free_idx_q] = 1'b1;
            if (grp_q == all_hosts_q || ifc_loop) begin
              mem_we          = 1'b1;
              mem_wa          = free_idx_q;
              mem_wd.iface    = ifc_q;
              mem_wd.group    = grp_q;
              mem_wd.timer    = 8'd0;
              mem_wd.rep_last = 1'b0;
            end else begin
              pk_d    = ifc_v1 ? KIND_V1_REPORT : KIND_V2_REPORT;
              pg_d    = grp_q;
              pd_d    = grp_q;
              pi_d    = ifc_q;
              state_d = S_EMIT;
            end
          end
        end else if (req_q == REQ_LEAVE) begin
          if (!found_q) begin
            st_d = ST_NOT_FOUND;
          end else begin
            valid_d[hit_q] = 1'b0;
            if (hit_rl_q && grp_q != all_hosts_q && !ifc_loop && !ifc_v1) begin
              pk_d    = KIND_LEAVE;
              pg_d    = grp_q;
              pd_d    = all_routers_q;
              pi_d    = ifc_q;
              state_d = S_EMIT;
            end
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          push = 1'b1;
          case (req_q)
            REQ_FAST: begin
              idx_d   = idx_q + CW'(1);
              state_d = S_RD;
            end
            REQ_JOIN: begin
              lfsr_d    = lfsr_step(lfsr_q);
              div_start = 1'b1;
              div_den   = (unsol_q == 8'd0) ? 8'd1 : unsol_q;
              state_d   = S_DIV;
            end
            default: state_d = S_STAT;
          endcase
        end
      end
      S_STAT: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid_i && cfg_index_i == CFG_SEED) lfsr_d = cfg_data_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[idx_q[IW-1:0]];
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      lfsr_q        <= 32'd1;
      valid_q       <= '0;
      v1_q          <= '0;
      for (int i = 0; i < IFACE_COUNT; i++) age_q[i] <= '0;
      loop_mask_q   <= 8'd0;
      fast_hz_q     <= 4'd5;
      unsol_q       <= 8'd50;
      age_lim_q     <= 16'd540;
      all_hosts_q   <= 32'hE000_0001;
      all_routers_q <= 32'hE000_0002;
      out_valid_q   <= 1'b0;
      st_q          <= ST_OK;
      idx_q         <= '0;
      found_q       <= 1'b0;
      free_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      lfsr_q  <= lfsr_d;
      valid_q <= valid_d;
      v1_q    <= v1_d;
      age_q   <= age_d;
      st_q    <= st_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      free_q  <= free_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LOOPBACK:    loop_mask_q   <= cfg_data_i[7:0];
          // seed goes straight into the lfsr
          CFG_SEED:        ;
          CFG_FAST_HZ:     fast_hz_q     <= cfg_data_i[3:0];
          CFG_UNSOLICITED: unsol_q       <= cfg_data_i[7:0];
          CFG_AGE_LIMIT:   age_lim_q     <= cfg_data_i[15:0];
          CFG_ALL_HOSTS:   all_hosts_q   <= cfg_data_i;
          CFG_ALL_ROUTERS: all_routers_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    hit_rl_q   <= hit_rl_d;
    hit_q      <= hit_d;
    free_idx_q <= free_idx_d;
    ent_q      <= ent_d;
    pk_q       <= pk_d;
    pg_q       <= pg_d;
    pd_q       <= pd_d;
    pi_q       <= pi_d;
    if (in_acc) begin
      req_q  <= req_type_i;
      ifc_q  <= iface_i;
      grp_q  <= group_addr_i;
      dst_q  <= dst_addr_i;
      code_q <= max_resp_code_i;
      self_q <= from_self_i;
      prod_q <= 12'(max_resp_code_i) * 12'(fast_hz_q);
    end
    if (push) begin
      ov_sv_q   <= !push_last;
      ov_kind_q <= push_last ? 2'd0 : pk_q;
      ov_grp_q  <= push_last ? 32'd0 : pg_q;
      ov_dst_q  <= push_last ? 32'd0 : pd_q;
      ov_ifc_q  <= push_last ? code_unused : pi_q;
      ov_st_q   <= push_last ? st_q : ST_OK;
      ov_last_q <= push_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign send_valid_o = ov_sv_q;
  assign send_kind_o  = ov_kind_q;
  assign send_group_o = ov_grp_q;
  assign send_dst_o   = ov_dst_q;
  assign send_iface_o = ov_ifc_q;
  assign status_o     = ov_st_q;
  assign last_o       = ov_last_q;
endmodule

// ===== rtl/igmphm_chk.sv =====
module igmphm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        send_valid_o,
  input logic [2:0]  status_o,
  input logic        last_o,
  input logic [31:0] send_group_o
);
  // output stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(send_group_o) && $stable(last_o))
    else $error("output changed while stalled");

  // one request in flight: ready drops right after a request is taken
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_status_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !send_valid_o && send_group_o == 32'd0)
    else $error("status item carries a send");

  a_send_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o |-> !last_o && status_o == 3'd0)
    else $error("send item marked last or with status");
endmodule

bind igmpv2_host_membership_engine igmphm_chk u_igmphm_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .send_valid_o (send_valid_o),
  .status_o     (status_o),
  .last_o       (last_o),
  .send_group_o (send_group_o)
);
